// File: src/assert_macros.svh
// assertion macros shared by the sorted priority queue modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/spq_pkg.sv
// package: sizes, codes and controller/datapath structs of the sorted priority queue
package spq_pkg;

  localparam int CAPACITY = 128;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 64;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = 8;
  localparam int ENTRY_W  = KEY_W + VAL_W;

  localparam logic [VAL_W-1:0] NEG_INF = 64'hFFF0_0000_0000_0000;

  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef logic [1:0] res_code_t;
  localparam res_code_t RES_INS   = 2'd0;
  localparam res_code_t RES_FULL  = 2'd1;
  localparam res_code_t RES_EMPTY = 2'd2;
  localparam res_code_t RES_EXT   = 2'd3;

  typedef struct packed {
    logic      capture;
    logic      shift;
    logic      place_next;
    logic      place_zero;
    logic      take;
    logic      set_res;
    res_code_t res;
    logic      load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic less;
    logic idx_zero;
    logic out_busy;
  } dp_stat_t;

endpackage

// File: src/spq_in_if.sv
// request channel: operation, key and payload
interface spq_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic signed [spq_pkg::KEY_W-1:0]    entry_key;
  logic        [spq_pkg::VAL_W-1:0]    entry_value;

  modport source (output valid, output mode, output entry_key, output entry_value,
                  input ready);
  modport sink   (input valid, input mode, input entry_key, input entry_value,
                  output ready);
endinterface

// File: src/spq_out_if.sv
// response channel: status, extracted payload and occupancy
interface spq_out_if;
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::STAT_W-1:0]   status;
  logic [spq_pkg::VAL_W-1:0]    out_value;
  logic [spq_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output out_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input out_value, input occupancy,
                  output ready);
endinterface

// File: src/spq_ram.sv
// generic single write port ram with registered read
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/spq_datapath.sv
// datapath: entry store, count, scan index and result register
`include "assert_macros.svh"

module spq_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  spq_pkg::dp_cmd_t                  cmd,
  output spq_pkg::dp_stat_t                 stat,
  input  logic signed [spq_pkg::KEY_W-1:0]  entry_key,
  input  logic [spq_pkg::VAL_W-1:0]         entry_value,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [spq_pkg::STAT_W-1:0]        status,
  output logic [spq_pkg::VAL_W-1:0]         out_value,
  output logic [spq_pkg::OCC_W-1:0]         occupancy
);

  logic [spq_pkg::CNT_W-1:0]          count;
  logic [spq_pkg::CNT_W-1:0]          count_dec;
  logic [spq_pkg::ADDR_W-1:0]         idx;
  logic [spq_pkg::ADDR_W-1:0]         idx_up;
  logic signed [spq_pkg::KEY_W-1:0]   key_in;
  logic [spq_pkg::VAL_W-1:0]          val_in;
  spq_pkg::res_code_t                 res_code;
  logic [spq_pkg::VAL_W-1:0]          res_value;

  logic                               wr_en;
  logic [spq_pkg::ADDR_W-1:0]         wr_addr;
  logic [spq_pkg::ENTRY_W-1:0]        wr_data;
  logic [spq_pkg::ADDR_W-1:0]         rd_addr;
  logic [spq_pkg::ENTRY_W-1:0]        rd_data;
  logic signed [spq_pkg::KEY_W-1:0]   rd_key;
  logic [spq_pkg::VAL_W-1:0]          rd_val;

  assign count_dec = count - spq_pkg::CNT_W'(1);
  assign idx_up    = idx + spq_pkg::ADDR_W'(1);
  assign rd_addr   = cmd.capture ? count_dec[spq_pkg::ADDR_W-1:0]
                                 : idx - spq_pkg::ADDR_W'(1);
  assign rd_key    = rd_data[spq_pkg::ENTRY_W-1 -: spq_pkg::KEY_W];
  assign rd_val    = rd_data[spq_pkg::VAL_W-1:0];

  // entry moves up one place, or the new entry lands in its slot
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_up;
    wr_data = rd_data;
    if (cmd.shift) begin
      wr_en = 1'b1;
    end else if (cmd.place_next) begin
      wr_en   = 1'b1;
      wr_data = {key_in, val_in};
    end else if (cmd.place_zero) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = {key_in, val_in};
    end
  end

  spq_ram #(
    .WIDTH (spq_pkg::ENTRY_W),
    .DEPTH (spq_pkg::CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.place_next || cmd.place_zero) begin
      count <= count + spq_pkg::CNT_W'(1);
    end else if (cmd.take) begin
      count <= count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx    <= count_dec[spq_pkg::ADDR_W-1:0];
      key_in <= entry_key;
      val_in <= entry_value;
    end else if (cmd.shift) begin
      idx <= idx - spq_pkg::ADDR_W'(1);
    end
    if (cmd.set_res) begin
      res_code <= cmd.res;
    end
    if (cmd.take) begin
      res_value <= rd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      occupancy <= spq_pkg::OCC_W'(count);
      case (res_code)
        spq_pkg::RES_FULL: begin
          status    <= spq_pkg::ST_FULL;
          out_value <= '0;
        end
        spq_pkg::RES_EMPTY: begin
          status    <= spq_pkg::ST_EMPTY;
          out_value <= spq_pkg::NEG_INF;
        end
        spq_pkg::RES_EXT: begin
          status    <= spq_pkg::ST_OK;
          out_value <= res_value;
        end
        default: begin
          status    <= spq_pkg::ST_OK;
          out_value <= '0;
        end
      endcase
    end
  end

  assign stat.empty    = (count == '0);
  assign stat.full     = (count == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
  assign stat.less     = (rd_key < key_in);
  assign stat.idx_zero = (idx == '0);
  assign stat.out_busy = out_valid && !out_ready;

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= spq_pkg::CNT_W'(spq_pkg::CAPACITY), "count over capacity")
  `SPQ_ASSERT_NEXT(a_place_inc, cmd.place_next || cmd.place_zero, count == $past(count) + spq_pkg::CNT_W'(1), "insert did not grow count")
  `SPQ_ASSERT_NEXT(a_take_dec, cmd.take, count == $past(count) - spq_pkg::CNT_W'(1), "extract did not shrink count")

endmodule

// File: src/spq_ctrl.sv
// controller: sequences insert scan, extract read and result hand-off
`include "assert_macros.svh"

module spq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_mode,
  input  spq_pkg::dp_stat_t stat,
  output logic              in_ready,
  output spq_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_TEST   = 3'd1;
  localparam logic [2:0] ST_PLACE0 = 3'd2;
  localparam logic [2:0] ST_EXT_RD = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_mode == spq_pkg::MODE_EXTRACT) begin
            if (stat.empty) begin
              cmd.set_res = 1'b1;
              cmd.res     = spq_pkg::RES_EMPTY;
              state_next  = ST_FIN;
            end else begin
              state_next = ST_EXT_RD;
            end
          end else if (stat.full) begin
            cmd.set_res = 1'b1;
            cmd.res     = spq_pkg::RES_FULL;
            state_next  = ST_FIN;
          end else if (stat.empty) begin
            state_next = ST_PLACE0;
          end else begin
            state_next = ST_TEST;
          end
        end
      end
      ST_TEST: begin
        if (stat.less) begin
          cmd.shift = 1'b1;
          if (stat.idx_zero) begin
            state_next = ST_PLACE0;
          end
        end else begin
          cmd.place_next = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res        = spq_pkg::RES_INS;
          state_next     = ST_FIN;
        end
      end
      ST_PLACE0: begin
        cmd.place_zero = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res        = spq_pkg::RES_INS;
        state_next     = ST_FIN;
      end
      ST_EXT_RD: begin
        cmd.take    = 1'b1;
        cmd.set_res = 1'b1;
        cmd.res     = spq_pkg::RES_EXT;
        state_next  = ST_FIN;
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `SPQ_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state != ST_IDLE, "transfer left controller idle")
  `SPQ_ASSERT_NOW(a_load_when_free, cmd.load_out, !stat.out_busy, "result loaded over pending transfer")
  `SPQ_ASSERT_NOW(a_single_write, 1'b1, $onehot0({cmd.shift, cmd.place_next, cmd.place_zero}), "two store writes at once")

endmodule

// File: src/sorted_priority_queue.sv
// top level: sorted priority queue of (key, value) entries, smallest key extracted first
//
//  channel  dir  fields                               transfer
//  req      in   mode, entry_key, entry_value         valid && ready
//  rsp      out  status, out_value, occupancy         valid && ready
//
//  insert: each entry with a smaller key moves up one place, one ram read/write a cycle
//  extract: one registered ram read of the tail; full insert or empty extract go straight to the result
//  one item at a time; req.ready is high only while the controller is idle
//  a result waiting on rsp holds the next item in its final cycle until taken
//  synchronous reset empties the queue; the store itself is not cleared
module sorted_priority_queue (
  input  logic      clk,
  input  logic      rst,
  spq_in_if.sink    req,
  spq_out_if.source rsp
);

  spq_pkg::dp_cmd_t  cmd;
  spq_pkg::dp_stat_t stat;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_mode  (req.mode),
    .stat     (stat),
    .in_ready (req.ready),
    .cmd      (cmd)
  );

  spq_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .entry_key   (req.entry_key),
    .entry_value (req.entry_value),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .status      (rsp.status),
    .out_value   (rsp.out_value),
    .occupancy   (rsp.occupancy)
  );

endmodule

// File: test/spq_order_checker.sv
// checker: tracks the held entries, predicts every response of the queue and compares it
module spq_order_checker
  import spq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  spq_in_if    req,
  spq_out_if   rsp,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  out_value;
    logic [OCC_W-1:0]  occupancy;
  } spq_rsp_t;

  // entries in descending key order, the smallest key at the tail
  logic signed [KEY_W-1:0] sorted_keys [CAPACITY];
  logic        [VAL_W-1:0] sorted_vals [CAPACITY];
  int                      held_count = 0;
  spq_rsp_t                due_rsp [$];
  int                      mismatches = 0;

  function automatic spq_rsp_t queue_step(input logic                    mode,
                                          input logic signed [KEY_W-1:0] key,
                                          input logic        [VAL_W-1:0] value);
    spq_rsp_t r;
    int       pos;
    int       i;
    r.status    = ST_OK;
    r.out_value = '0;
    if (mode == MODE_INSERT) begin
      if (held_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && key <= sorted_keys[pos]) pos++;
        for (i = held_count; i > pos; i--) begin
          sorted_keys[i] = sorted_keys[i-1];
          sorted_vals[i] = sorted_vals[i-1];
        end
        sorted_keys[pos] = key;
        sorted_vals[pos] = value;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status    = ST_EMPTY;
        r.out_value = NEG_INF;
      end else begin
        held_count--;
        r.out_value = sorted_vals[held_count];
      end
    end
    r.occupancy = OCC_W'(held_count);
    return r;
  endfunction

  function automatic void note_failure(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endfunction

  always @(posedge clk) begin
    spq_rsp_t want;
    spq_rsp_t got;
    if (rst) begin
      held_count = 0;
      due_rsp.delete();
    end else begin
      if (req.valid && req.ready)
        due_rsp.push_back(queue_step(req.mode, req.entry_key, req.entry_value));
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.out_value, rsp.occupancy};
        if (due_rsp.size() == 0) begin
          note_failure($sformatf("unexpected response status=%0d value=%h occupancy=%0d",
                                 got.status, got.out_value, got.occupancy));
        end else begin
          want = due_rsp.pop_front();
          if (want.status !== got.status || want.out_value !== got.out_value ||
              want.occupancy !== got.occupancy)
            note_failure($sformatf(
              "status exp %0d got %0d, value exp %h got %h, occupancy exp %0d got %0d",
              want.status, got.status, want.out_value, got.out_value,
              want.occupancy, got.occupancy));
        end
      end
    end
    fail_count <= mismatches;
    pending    <= due_rsp.size();
  end

endmodule

// File: test/sorted_priority_queue_tb.sv
// testbench top: drives random and directed queue operations and gives the verdict
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int LONG_HOLD    = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int          fail_count;
  int          pending;
  int unsigned cycles = 0;
  bit          burst = 1'b0;

  spq_in_if  req ();
  spq_out_if rsp ();

  sorted_priority_queue u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  spq_order_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // small keys give many equal keys, plus the signed extremes
  function automatic logic signed [KEY_W-1:0] rand_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return KEY_W'($urandom_range(0, 15)) - KEY_W'(8);
    if (r < 6) begin
      case ($urandom_range(0, 3))
        0:       return {1'b1, {(KEY_W-1){1'b0}}};
        1:       return {1'b0, {(KEY_W-1){1'b1}}};
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic send(input logic                    mode,
                      input logic signed [KEY_W-1:0] key,
                      input logic        [VAL_W-1:0] value);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.mode        <= mode;
    req.entry_key   <= key;
    req.entry_value <= value;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // sender pauses until every response is back
  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random stalls, with a long hold-off after 200 responses and every 700 after that
  initial begin : rsp_side
    int stall;
    int run;
    int taken;
    int next_hold;
    taken     = 0;
    next_hold = 200;
    rsp.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken >= next_hold) begin
        stall     = LONG_HOLD;
        next_hold = next_hold + 700;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      repeat (run) begin
        @(posedge clk);
        if (rsp.valid && rsp.ready) taken++;
      end
    end
  end

  initial begin : req_side
    int done;
    int plen;
    int pins;
    int i;
    req.valid       = 1'b0;
    req.mode        = MODE_INSERT;
    req.entry_key   = '0;
    req.entry_value = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty extract, key extremes, equal keys, drain to empty again
    send(MODE_EXTRACT, rand_key(), rand_value());
    send(MODE_INSERT, {1'b0, {(KEY_W-1){1'b1}}}, '1);
    send(MODE_INSERT, {1'b1, {(KEY_W-1){1'b0}}}, '0);
    send(MODE_INSERT, '0, {(VAL_W/2){2'b01}});
    send(MODE_INSERT, '1, {(VAL_W/2){2'b10}});
    send(MODE_INSERT, KEY_W'(5), 64'h0123_4567_89ab_cdef);
    send(MODE_INSERT, KEY_W'(5), 64'hfedc_ba98_7654_3210);
    send(MODE_INSERT, {1'b1, {(KEY_W-1){1'b0}}}, 64'h0000_0000_ffff_ffff);
    for (i = 0; i < 8; i++) send(MODE_EXTRACT, rand_key(), rand_value());
    send(MODE_EXTRACT, '1, '1);
    settle();

    // fill past capacity, then drain past empty
    for (i = 0; i < CAPACITY + 8; i++) send(MODE_INSERT, rand_key(), rand_value());
    settle();
    for (i = 0; i < CAPACITY + 8; i++) send(MODE_EXTRACT, rand_key(), rand_value());
    done = 2 * (CAPACITY + 8);

    while (done < RANDOM_ITEMS) begin
      plen = $urandom_range(40, 200);
      case ($urandom_range(0, 3))
        0:       pins = 92;
        1:       pins = 8;
        2:       pins = 50;
        default: pins = 70;
      endcase
      burst = ($urandom_range(0, 3) == 0);
      repeat (plen)
        send(($urandom_range(0, 99) < pins) ? MODE_INSERT : MODE_EXTRACT,
             rand_key(), rand_value());
      done = done + plen;
      if ($urandom_range(0, 2) == 0) settle();
    end
    burst = 1'b0;

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/spq_pkg.sv
src/spq_in_if.sv
src/spq_out_if.sv
src/spq_ram.sv
src/spq_datapath.sv
src/spq_ctrl.sv
src/sorted_priority_queue.sv
test/spq_order_checker.sv
test/sorted_priority_queue_tb.sv
